// ----- rtl/btps_pkg.sv -----
// Shared types, constants and segment tables of the bit-sliced ternary sampler.
`default_nettype none

package btps_pkg;

    // Segment geometry.
    localparam int SEGMENT_LEN = 128;
    localparam int KEY_BYTES   = 32;

    localparam int ENTRY_W = $clog2(SEGMENT_LEN);
    localparam int OFF_W   = ($clog2(2 * SEGMENT_LEN) > $clog2(KEY_BYTES)) ?
                             $clog2(2 * SEGMENT_LEN) : $clog2(KEY_BYTES);

    // Field widths of the result transaction.
    localparam int KIND_W      = 2;
    localparam int COEFF_IDX_W = 10;
    localparam int COEFF_W     = 2;
    localparam int BYTE_W      = 8;
    localparam int MODE_W      = 2;
    localparam int SEG_W       = 3;
    localparam int SUB_W       = 3;

    // Width used while forming a coefficient index before it wraps to ten bits.
    localparam int IDX_CALC_W = ($clog2(8 * SEGMENT_LEN) + 1 > COEFF_IDX_W) ?
                                $clog2(8 * SEGMENT_LEN) + 1 : COEFF_IDX_W;

    // Depth of the queue between the front and the back.
    localparam int Q_DEPTH = 4;
    localparam int QPTR_W  = $clog2(Q_DEPTH);
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    // Sampling modes.
    localparam logic [MODE_W-1:0] MODE_KEY_F_G = 2'd0;
    localparam logic [MODE_W-1:0] MODE_F_ONLY  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_G_ONLY  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_S_E     = 2'd3;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_KEY    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FIRST  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SECOND = 2'd2;

    // Operation applied to the bytes of one segment.
    typedef enum logic [2:0] {
        OP_KEY,
        OP_AND_STORE,
        OP_AND_SUB_STORE,
        OP_AND_SUB_OUT,
        OP_MASK,
        OP_DIFF1,
        OP_DIFF2
    } t_op;

    // Shape of the results that one queued byte expands into.
    typedef enum logic [1:0] {
        JOB_KEY,
        JOB_MASK,
        JOB_PAIR
    } t_job;

    typedef struct packed {
        t_job                          job;
        logic [KIND_W-1:0]             kind;
        logic [OFF_W-1:0]              base;
        logic [BYTE_W-1:0]             key;
        logic [7:0][COEFF_W-1:0]       vals;
        logic                          run_done;
    } t_job_entry;

    // Operation of segment seg in mode mode.
    function automatic t_op seg_op(input logic [MODE_W-1:0] mode, input logic [SEG_W-1:0] seg);
        t_op op;
        op = OP_KEY;
        unique case (mode)
            MODE_KEY_F_G: begin
                case (seg)
                    3'd0:    op = OP_KEY;
                    3'd1:    op = OP_AND_STORE;
                    3'd2:    op = OP_AND_SUB_STORE;
                    3'd3:    op = OP_MASK;
                    default: op = OP_DIFF2;
                endcase
            end
            MODE_F_ONLY: begin
                case (seg)
                    3'd0:    op = OP_AND_STORE;
                    3'd1:    op = OP_AND_SUB_STORE;
                    default: op = OP_MASK;
                endcase
            end
            MODE_G_ONLY: begin
                op = OP_DIFF1;
            end
            default: begin
                case (seg)
                    3'd0:    op = OP_AND_STORE;
                    3'd1:    op = OP_AND_SUB_OUT;
                    default: op = OP_DIFF2;
                endcase
            end
        endcase
        return op;
    endfunction

    // Index of the final segment of a run in mode mode.
    function automatic logic [SEG_W-1:0] last_seg(input logic [MODE_W-1:0] mode);
        logic [SEG_W-1:0] s;
        unique case (mode)
            MODE_KEY_F_G: s = 3'd4;
            MODE_F_ONLY:  s = 3'd2;
            MODE_G_ONLY:  s = 3'd0;
            default:      s = 3'd2;
        endcase
        return s;
    endfunction

    // Offset of the final byte of a segment with operation op.
    function automatic logic [OFF_W-1:0] seg_last_off(input t_op op);
        logic [OFF_W-1:0] v;
        unique case (op)
            OP_KEY:  v = OFF_W'(KEY_BYTES - 1);
            OP_MASK: v = OFF_W'(SEGMENT_LEN - 1);
            default: v = OFF_W'(2 * SEGMENT_LEN - 1);
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/bitsliced_ternary_poly_sampler.sv -----
// Top level of the bit-sliced ternary polynomial sampler.
`default_nettype none

// Bit-sliced ternary polynomial sampler. Feed it the XOF stream one byte per
// input transaction and mark the first byte of each run with run_start; the
// run follows the layout of the mode that was written to sample_mode before
// the run began. Write sample_mode only while the block is idle. The front end
// takes one byte per cycle: store-only bytes (the AND-store and AND-subtract
// segments) produce no result transactions, so they stream at one byte per
// cycle whenever the job queue has room. A key byte produces one result, a
// pair-segment output byte four and a mask byte eight, and the result
// sequencer issues one result transaction per cycle while the output is not
// stalled, so a mask byte holds the sequencer longer than a pair byte or a key.
// A four-entry job queue sits between the front end and the sequencer, and
// the output register is reloaded at the same edge that takes its result, so
// results follow back to back. With the queue empty, the first result of a
// byte passes the second-stage register, the queue and the output register.
// The partial store is a 128-word by 16-bit memory with one read and one
// lane-masked write per cycle; it needs no clearing after reset because every
// word is written earlier in a run before that run reads it. Bytes that arrive
// with no run active are dropped without results.
module bitsliced_ternary_poly_sampler (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_sample_mode,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_random_byte,
    input  wire logic        i_run_start,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_item_kind,
    output logic [9:0]       o_coeff_index,
    output logic signed [1:0] o_coeff_value,
    output logic [7:0]       o_key_value,
    output logic             o_last_of_byte,
    output logic             o_run_done
);
    import btps_pkg::*;

    logic              push;
    t_job_entry        push_entry;
    logic              pop;
    logic              head_valid;
    t_job_entry        head_entry;
    logic [QCNT_W-1:0] q_count;

    // The mode register accepts a write in every cycle.
    assign o_cfg_ready = 1'b1;

    // The front end classifies each byte by its place in the run and keeps
    // the partial store up to date.
    btps_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_sample_mode (i_sample_mode),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_random_byte (i_random_byte),
        .i_run_start   (i_run_start),
        .i_q_count     (q_count),
        .o_push        (push),
        .o_push_entry  (push_entry)
    );

    // Jobs wait here until the sequencer has issued the results before them.
    btps_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_entry (push_entry),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head_entry (head_entry),
        .o_count      (q_count)
    );

    // The sequencer turns each job into its result transactions in order.
    btps_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head_valid   (head_valid),
        .i_head_entry   (head_entry),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_item_kind    (o_item_kind),
        .o_coeff_index  (o_coeff_index),
        .o_coeff_value  (o_coeff_value),
        .o_key_value    (o_key_value),
        .o_last_of_byte (o_last_of_byte),
        .o_run_done     (o_run_done)
    );

endmodule

`default_nettype wire

// ----- rtl/btps_front.sv -----
// Front end: accepts bytes, tracks the run layout, updates the partial store, builds jobs.
`default_nettype none

module btps_front (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_valid,
    input  wire logic [1:0]                i_sample_mode,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic [7:0]                i_random_byte,
    input  wire logic                      i_run_start,
    input  wire logic [btps_pkg::QCNT_W-1:0] i_q_count,
    output logic                           o_push,
    output btps_pkg::t_job_entry           o_push_entry
);
    import btps_pkg::*;

    logic [MODE_W-1:0]  r_sample_mode;
    logic [MODE_W-1:0]  r_mode;
    logic               r_active;
    logic [SEG_W-1:0]   r_seg;
    logic [OFF_W-1:0]   r_off;

    // Second stage: the byte whose store word has been read into r_rd_data.
    logic               r_b_valid;
    t_op                r_b_op;
    logic [OFF_W-1:0]   r_b_off;
    logic               r_b_hi;
    logic [ENTRY_W-1:0] r_b_entry;
    logic [BYTE_W-1:0]  r_b_byte;
    logic               r_b_done;
    logic [15:0]        r_rd_data;

    logic [15:0]        r_store [SEGMENT_LEN];

    logic               accept;
    logic               cur_active;
    logic [MODE_W-1:0]  cur_mode;
    logic [SEG_W-1:0]   cur_seg;
    logic [OFF_W-1:0]   cur_off;
    t_op                cur_op;
    logic               seg_end;
    logic               run_end;
    logic               cur_hi;
    logic [OFF_W-1:0]   cur_entry_full;
    logic [7:0]         lane_we;
    logic [7:0][1:0]    lane_data;
    logic [7:0][1:0]    vals;
    logic [QCNT_W:0]    fill;

    // Room is reserved for the job that the second stage may push next edge.
    assign fill       = {1'b0, i_q_count} + (QCNT_W + 1)'(o_push);
    assign o_in_stall = (fill >= (QCNT_W + 1)'(Q_DEPTH));
    assign accept     = i_in_valid & ~o_in_stall;

    always_comb begin
        cur_active     = i_run_start | r_active;
        cur_mode       = i_run_start ? r_sample_mode : r_mode;
        cur_seg        = i_run_start ? '0 : r_seg;
        cur_off        = i_run_start ? '0 : r_off;
        cur_op         = seg_op(cur_mode, cur_seg);
        seg_end        = (cur_off == seg_last_off(cur_op));
        run_end        = seg_end && (cur_seg == last_seg(cur_mode));
        cur_hi         = (cur_off >= OFF_W'(SEGMENT_LEN));
        cur_entry_full = cur_hi ? (cur_off - OFF_W'(SEGMENT_LEN)) : cur_off;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_mode <= MODE_KEY_F_G;
            r_mode        <= MODE_KEY_F_G;
            r_active      <= 1'b0;
            r_seg         <= '0;
            r_off         <= '0;
            r_b_valid     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_sample_mode <= i_sample_mode;
            end
            r_b_valid <= accept & cur_active;
            if (accept && cur_active) begin
                r_mode   <= cur_mode;
                r_active <= ~run_end;
                r_seg    <= seg_end ? cur_seg + SEG_W'(1) : cur_seg;
                r_off    <= seg_end ? '0 : cur_off + OFF_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b_op    <= cur_op;
            r_b_off   <= cur_off;
            r_b_hi    <= cur_hi;
            r_b_entry <= cur_entry_full[ENTRY_W-1:0];
            r_b_byte  <= i_random_byte;
            r_b_done  <= run_end;
            r_rd_data <= r_store[cur_entry_full[ENTRY_W-1:0]];
        end
    end

    // Per-lane results of the byte in the second stage.
    always_comb begin
        logic       lo;
        logic       up;
        logic [1:0] a;
        logic [1:0] old;
        lane_we   = '0;
        lane_data = '0;
        vals      = '0;
        for (int k = 0; k < 4; k++) begin
            lo  = r_b_byte[k];
            up  = r_b_byte[k + 4];
            a   = {1'b0, lo & up};
            old = r_b_hi ? r_rd_data[(2 * k + 1) * 2 +: 2] : r_rd_data[(2 * k) * 2 +: 2];
            case (r_b_op) inside
                OP_AND_STORE: begin
                    lane_we[2 * k + 1]   = r_b_hi;
                    lane_we[2 * k]       = ~r_b_hi;
                    lane_data[2 * k + 1] = a;
                    lane_data[2 * k]     = a;
                end
                OP_AND_SUB_STORE: begin
                    lane_we[2 * k + 1]   = r_b_hi;
                    lane_we[2 * k]       = ~r_b_hi;
                    lane_data[2 * k + 1] = old - a;
                    lane_data[2 * k]     = old - a;
                end
                OP_AND_SUB_OUT: begin
                    vals[k] = old - a;
                end
                OP_DIFF1, OP_DIFF2: begin
                    vals[k] = {1'b0, lo} - {1'b0, up};
                end
                default: begin
                end
            endcase
        end
        if (r_b_op == OP_MASK) begin
            for (int i = 0; i < 8; i++) begin
                vals[i] = r_b_byte[i] ? r_rd_data[2 * i +: 2] : 2'b00;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_b_valid) begin
            for (int l = 0; l < 8; l++) begin
                if (lane_we[l]) begin
                    r_store[r_b_entry][2 * l +: 2] <= lane_data[l];
                end
            end
        end
    end

    always_comb begin
        o_push                = r_b_valid && (r_b_op != OP_AND_STORE) &&
                                (r_b_op != OP_AND_SUB_STORE);
        o_push_entry.base     = r_b_off;
        o_push_entry.key      = r_b_byte;
        o_push_entry.vals     = vals;
        o_push_entry.run_done = r_b_done;
        case (r_b_op)
            OP_KEY: begin
                o_push_entry.job  = JOB_KEY;
                o_push_entry.kind = KIND_KEY;
            end
            OP_MASK: begin
                o_push_entry.job  = JOB_MASK;
                o_push_entry.kind = KIND_FIRST;
            end
            OP_DIFF2: begin
                o_push_entry.job  = JOB_PAIR;
                o_push_entry.kind = KIND_SECOND;
            end
            default: begin
                o_push_entry.job  = JOB_PAIR;
                o_push_entry.kind = KIND_FIRST;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/btps_queue.sv -----
// Short job queue between the front end and the result sequencer.
`default_nettype none

module btps_queue (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_push,
    input  wire btps_pkg::t_job_entry        i_push_entry,
    input  wire logic                        i_pop,
    output logic                             o_head_valid,
    output btps_pkg::t_job_entry             o_head_entry,
    output logic [btps_pkg::QCNT_W-1:0]      o_count
);
    import btps_pkg::*;

    t_job_entry        r_slots [Q_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_pop;

    assign do_pop       = i_pop & (r_count != '0);
    assign o_head_valid = (r_count != '0);
    assign o_head_entry = r_slots[r_rd_ptr];
    assign o_count      = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + QPTR_W'(1);
            end
            r_count <= r_count + QCNT_W'(i_push) - QCNT_W'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slots[r_wr_ptr] <= i_push_entry;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/btps_back.sv -----
// Result sequencer: expands queued jobs into results, one per cycle unless stalled.
`default_nettype none

module btps_back (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_head_valid,
    input  wire btps_pkg::t_job_entry         i_head_entry,
    output logic                              o_pop,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic [1:0]                        o_item_kind,
    output logic [9:0]                        o_coeff_index,
    output logic signed [1:0]                 o_coeff_value,
    output logic [7:0]                        o_key_value,
    output logic                              o_last_of_byte,
    output logic                              o_run_done
);
    import btps_pkg::*;

    logic [SUB_W-1:0]      r_k;
    logic                  r_out_valid;
    logic [KIND_W-1:0]     r_kind;
    logic [COEFF_IDX_W-1:0] r_index;
    logic [COEFF_W-1:0]    r_value;
    logic [BYTE_W-1:0]     r_key;
    logic                  r_last;
    logic                  r_done;

    logic                  load;
    logic [SUB_W-1:0]      k_last;
    logic                  is_last;
    logic [IDX_CALC_W-1:0] stride;
    logic [IDX_CALC_W-1:0] idx_full;

    assign load = i_head_valid & (~r_out_valid | ~i_out_stall);

    always_comb begin
        case (i_head_entry.job)
            JOB_KEY: begin
                k_last = SUB_W'(0);
                stride = '0;
            end
            JOB_MASK: begin
                k_last = SUB_W'(7);
                stride = IDX_CALC_W'(SEGMENT_LEN);
            end
            default: begin
                k_last = SUB_W'(3);
                stride = IDX_CALC_W'(2 * SEGMENT_LEN);
            end
        endcase
        is_last  = (r_k == k_last);
        idx_full = IDX_CALC_W'(r_k) * stride + IDX_CALC_W'(i_head_entry.base);
        o_pop    = load & is_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_k         <= is_last ? '0 : r_k + SUB_W'(1);
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind  <= i_head_entry.kind;
            r_index <= idx_full[COEFF_IDX_W-1:0];
            r_last  <= is_last;
            r_done  <= is_last & i_head_entry.run_done;
            if (i_head_entry.job == JOB_KEY) begin
                r_value <= '0;
                r_key   <= i_head_entry.key;
            end else begin
                r_value <= i_head_entry.vals[r_k];
                r_key   <= '0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_item_kind    = r_kind;
    assign o_coeff_index  = r_index;
    assign o_coeff_value  = r_value;
    assign o_key_value    = r_key;
    assign o_last_of_byte = r_last;
    assign o_run_done     = r_done;

endmodule

`default_nettype wire

// ----- verif/bitsliced_ternary_poly_sampler_tb.sv -----
// Self-checking testbench of the bit-sliced ternary polynomial sampler, with its own predictor.
`timescale 1ns / 100ps

module bitsliced_ternary_poly_sampler_tb;
    import btps_pkg::*;

    // Longest stretch of cycles without any accepted transaction before the test fails and stops.
    localparam int IDLE_LIMIT    = 2000;
    // Cycles allowed after the last expected sample, so that silent bytes leave the pipeline.
    localparam int SETTLE_CYCLES = 12;

    // One byte of the XOF stream together with its run marker.
    typedef struct packed {
        logic [7:0] data;
        logic       start;
    } t_xof_item;

    // One expected output transaction of the sampler.
    typedef struct packed {
        logic [1:0] kind;
        logic [9:0] index;
        logic [1:0] value;
        logic [7:0] key;
        logic       last;
        logic       done;
    } t_sample;

    logic              i_clk          = 1'b0;
    logic              i_rst_n        = 1'b0;
    logic              i_cfg_valid    = 1'b0;
    logic [1:0]        i_sample_mode  = MODE_KEY_F_G;
    logic              i_in_valid     = 1'b0;
    logic [7:0]        i_random_byte  = 8'h00;
    logic              i_run_start    = 1'b0;
    logic              i_out_stall    = 1'b0;
    logic              o_cfg_ready;
    logic              o_in_stall;
    logic              o_out_valid;
    logic [1:0]        o_item_kind;
    logic [9:0]        o_coeff_index;
    logic signed [1:0] o_coeff_value;
    logic [7:0]        o_key_value;
    logic              o_last_of_byte;
    logic              o_run_done;

    // Bytes waiting to be offered to the sampler, and samples it still owes us.
    t_xof_item xof_bytes[$];
    t_sample   pending_samples[$];

    // Random idling of the two sides, in percent of cycles.
    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;

    int mismatch_count = 0;
    int idle_cycles    = 0;

    // Predictor state: the mode register, the mode latched by the current run, the position
    // inside the run, and the store of two-bit partial values (entry, slot).
    logic [1:0] mode_reg_copy = MODE_KEY_F_G;
    logic [1:0] latched_mode  = MODE_KEY_F_G;
    int         byte_pos      = 0;
    logic       run_on        = 1'b0;
    logic [1:0] lanes [SEGMENT_LEN][8];

    bitsliced_ternary_poly_sampler DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_sample_mode  (i_sample_mode),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_random_byte  (i_random_byte),
        .i_run_start    (i_run_start),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_item_kind    (o_item_kind),
        .o_coeff_index  (o_coeff_index),
        .o_coeff_value  (o_coeff_value),
        .o_key_value    (o_key_value),
        .o_last_of_byte (o_last_of_byte),
        .o_run_done     (o_run_done)
    );

    // 4 ns clock period.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Number of segments in a run of the given mode.
    function automatic int segment_count(input logic [1:0] m);
        case (m)
            MODE_KEY_F_G: return 5;
            MODE_G_ONLY:  return 1;
            default:      return 3;
        endcase
    endfunction

    // Operation applied to segment s of a run in mode m.
    function automatic t_op segment_op(input logic [1:0] m, input int s);
        t_op op;
        op = OP_DIFF2;
        case (m)
            MODE_KEY_F_G: begin
                if (s == 0)      op = OP_KEY;
                else if (s == 1) op = OP_AND_STORE;
                else if (s == 2) op = OP_AND_SUB_STORE;
                else if (s == 3) op = OP_MASK;
            end
            MODE_F_ONLY: begin
                op = (s == 0) ? OP_AND_STORE : (s == 1) ? OP_AND_SUB_STORE : OP_MASK;
            end
            MODE_G_ONLY: begin
                op = OP_DIFF1;
            end
            default: begin
                op = (s == 0) ? OP_AND_STORE : (s == 1) ? OP_AND_SUB_OUT : OP_DIFF2;
            end
        endcase
        return op;
    endfunction

    // Key segments are KEY_BYTES long, mask segments one segment length, pair segments two.
    function automatic int segment_bytes(input t_op op);
        if (op == OP_KEY) return KEY_BYTES;
        if (op == OP_MASK) return SEGMENT_LEN;
        return 2 * SEGMENT_LEN;
    endfunction

    function automatic int run_bytes(input logic [1:0] m);
        int total;
        total = 0;
        for (int s = 0; s < segment_count(m); s++) total += segment_bytes(segment_op(m, s));
        return total;
    endfunction

    function automatic t_sample make_sample(input logic [1:0] kind, input logic [9:0] index,
                                            input logic [1:0] value, input logic [7:0] key);
        t_sample r;
        r.kind  = kind;
        r.index = index;
        r.value = value;
        r.key   = key;
        r.last  = 1'b0;
        r.done  = 1'b0;
        return r;
    endfunction

    // Advances the predictor by one accepted byte and queues the samples that it yields.
    task automatic predict_samples(input logic [7:0] b, input logic start);
        t_sample    batch [8];
        int         n;
        int         rel;
        int         s;
        int         entry;
        int         slot;
        logic       hi;
        logic       pair;
        logic [9:0] idx;
        t_op        op;
        n = 0;
        if (start) begin
            byte_pos     = 0;
            run_on       = 1'b1;
            latched_mode = mode_reg_copy;
        end
        if (run_on) begin
            // Find the segment that holds this byte and the offset inside it.
            rel = byte_pos;
            s   = 0;
            op  = segment_op(latched_mode, 0);
            while (rel >= segment_bytes(op)) begin
                rel -= segment_bytes(op);
                s++;
                op = segment_op(latched_mode, s);
            end
            hi    = (rel >= SEGMENT_LEN);
            entry = hi ? rel - SEGMENT_LEN : rel;

            case (op)
                OP_KEY: begin
                    batch[n] = make_sample(KIND_KEY, 10'(rel), 2'b00, b);
                    n++;
                end
                OP_MASK: begin
                    // Each mask bit selects the partial value of one coefficient or zeroes it.
                    for (int k = 0; k < 8; k++) begin
                        batch[n] = make_sample(KIND_FIRST, 10'(k * SEGMENT_LEN + rel),
                                               b[k] ? lanes[entry][k] : 2'b00, 8'h00);
                        n++;
                    end
                end
                default: begin
                    // Pair segments: bits k and k+4 form coefficient k*2D+rel. The upper half
                    // of the segment uses the odd slots of the same store entry.
                    for (int k = 0; k < 4; k++) begin
                        pair = b[k] & b[k + 4];
                        slot = 2 * k + int'(hi);
                        idx  = 10'(k * 2 * SEGMENT_LEN + rel);
                        case (op)
                            OP_AND_STORE: begin
                                lanes[entry][slot] = {1'b0, pair};
                            end
                            OP_AND_SUB_STORE: begin
                                lanes[entry][slot] = lanes[entry][slot] - {1'b0, pair};
                            end
                            OP_AND_SUB_OUT: begin
                                batch[n] = make_sample(KIND_FIRST, idx,
                                                       lanes[entry][slot] - {1'b0, pair}, 8'h00);
                                n++;
                            end
                            default: begin
                                batch[n] = make_sample(op == OP_DIFF1 ? KIND_FIRST : KIND_SECOND,
                                                       idx, {1'b0, b[k]} - {1'b0, b[k + 4]},
                                                       8'h00);
                                n++;
                            end
                        endcase
                    end
                end
            endcase

            byte_pos++;
            if (byte_pos >= run_bytes(latched_mode)) run_on = 1'b0;
            if (n > 0) begin
                batch[n - 1].last = 1'b1;
                batch[n - 1].done = !run_on;
            end
            for (int i = 0; i < n; i++) pending_samples.push_back(batch[i]);
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    // Driver: offers queued bytes and holds each one until it is taken. When the current
    // transaction completes, the next one, if any is queued and the driver does not idle,
    // is loaded in the same edge, so valid stays high across back-to-back transactions.
    always @(posedge i_clk) begin : xof_driver
        t_xof_item next_item;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (xof_bytes.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
                next_item = xof_bytes.pop_front();
                i_in_valid    <= 1'b1;
                i_random_byte <= next_item.data;
                i_run_start   <= next_item.start;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Monitor: follows register writes and accepted bytes in the predictor, checks each
    // accepted sample against the oldest expectation, and draws the stall for the next cycle.
    // All values are read at the clock edge, before the edge's own updates take effect.
    always @(posedge i_clk) begin : sample_monitor
        t_sample want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) mode_reg_copy = i_sample_mode;
            if (i_in_valid && !o_in_stall) predict_samples(i_random_byte, i_run_start);
            if (o_out_valid && !i_out_stall) begin
                if (pending_samples.size() == 0) begin
                    report_mismatch($sformatf("unexpected sample kind %0d index %0d",
                                              o_item_kind, o_coeff_index));
                end else begin
                    want = pending_samples.pop_front();
                    if (o_item_kind !== want.kind)
                        report_mismatch($sformatf("index %0d: item_kind %0d, expected %0d",
                                                  want.index, o_item_kind, want.kind));
                    if (o_coeff_index !== want.index)
                        report_mismatch($sformatf("coeff_index %0d, expected %0d",
                                                  o_coeff_index, want.index));
                    if (o_coeff_value !== want.value)
                        report_mismatch($sformatf("index %0d: coeff_value %0d, expected %0d",
                                                  want.index, o_coeff_value,
                                                  $signed(want.value)));
                    if (o_key_value !== want.key)
                        report_mismatch($sformatf("index %0d: key_value %0h, expected %0h",
                                                  want.index, o_key_value, want.key));
                    if (o_last_of_byte !== want.last)
                        report_mismatch($sformatf("index %0d: last_of_byte %0b, expected %0b",
                                                  want.index, o_last_of_byte, want.last));
                    if (o_run_done !== want.done)
                        report_mismatch($sformatf("index %0d: run_done %0b, expected %0b",
                                                  want.index, o_run_done, want.done));
                end
            end
            i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Watchdog: any accepted transaction on any channel restarts the count.
    always @(posedge i_clk) begin : idle_watchdog
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic push_byte(input logic [7:0] data, input logic start);
        t_xof_item it;
        it.data  = data;
        it.start = start;
        xof_bytes.push_back(it);
    endtask

    // Random bytes without a run marker: continuation of a run, or surplus and idle bytes.
    task automatic queue_plain(input int n);
        for (int i = 0; i < n; i++) push_byte(8'($urandom_range(0, 255)), 1'b0);
    endtask

    // A run of n random bytes, the first one carrying the run marker.
    task automatic queue_run(input int n);
        push_byte(8'($urandom_range(0, 255)), 1'b1);
        queue_plain(n - 1);
    endtask

    // Waits until every byte is taken and every sample has arrived, then lets the pipeline
    // drain of bytes that yield nothing.
    task automatic wait_idle();
        do @(posedge i_clk);
        while (xof_bytes.size() != 0 || i_in_valid || pending_samples.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes the mode register once the sampler has gone quiet.
    task automatic write_mode(input logic [1:0] m);
        wait_idle();
        i_cfg_valid   <= 1'b1;
        i_sample_mode <= m;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // One phase of random stimulus: an abandoned run, a run of mode_a with the register
    // rewritten in the middle of it, then the start of a run of mode_b.
    task automatic run_phase(input int send_pct, input int stall_pct,
                             input logic [1:0] mode_a, input logic [1:0] mode_b);
        sender_idle_pct = send_pct;
        recv_stall_pct  = stall_pct;
        write_mode(mode_a);
        queue_run($urandom_range(1, 8));
        queue_run($urandom_range(1, 8));
        // The run in flight must keep the mode that it latched at its start.
        write_mode(~mode_a);
        queue_plain($urandom_range(1, 8));
        write_mode(mode_b);
        queue_run($urandom_range(4, 12));
        queue_plain($urandom_range(1, 3));
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, without idling. Bytes before any run are dropped.
        write_mode(MODE_KEY_F_G);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        // Key bytes at the extremes of the byte range.
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'h01, 1'b0);
        push_byte(8'h7F, 1'b0);
        // A mode change inside the run does not touch it: this is still a key byte.
        write_mode(MODE_G_ONLY);
        push_byte(8'hA5, 1'b0);
        // Restart in g-only mode. The differences cover +1, -1 and both kinds of zero.
        push_byte(8'h0F, 1'b1);
        push_byte(8'hF0, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h5A, 1'b0);
        push_byte(8'hC3, 1'b0);

        // Random part: one phase per idling pattern, each mode once as mode_a and once as mode_b.
        run_phase(0, 0, MODE_KEY_F_G, MODE_S_E);
        run_phase(47, 0, MODE_F_ONLY, MODE_G_ONLY);
        run_phase(0, 47, MODE_S_E, MODE_KEY_F_G);
        run_phase(33, 33, MODE_G_ONLY, MODE_F_ONLY);

        wait_idle();
        if (mismatch_count == 0 && pending_samples.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
